>>> rtl/core/axd_pkg.sv
// ----------------------------------------------------------------------------
// axd_pkg
// Shared types, codes and the CRC-16/X.25 byte update for the UI frame decoder.
// ----------------------------------------------------------------------------
package axd_pkg;

    localparam int MAX_REPEATERS  = 8;
    localparam int MAX_INFO_BYTES = 256;

    localparam int CFG_W      = 9;
    localparam int INFO_CNT_W = $clog2(MAX_INFO_BYTES + 1);
    localparam int LIM_W      = (INFO_CNT_W > CFG_W) ? INFO_CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  CTRL_UI    = 8'h03;
    localparam logic [7:0]  PID_NONE   = 8'hF0;
    localparam logic [6:0]  SPACE_CHAR = 7'h20;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    // result kinds
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_SSID    = 2'd1;
    localparam logic [1:0] KIND_INFO    = 2'd2;
    localparam logic [1:0] KIND_VERDICT = 2'd3;

    // verdict codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_OPEN  = 3'd1;
    localparam logic [2:0] STAT_BAD_CLOSE = 3'd2;
    localparam logic [2:0] STAT_TRUNC     = 3'd3;
    localparam logic [2:0] STAT_BAD_CTRL  = 3'd4;
    localparam logic [2:0] STAT_BAD_PID   = 3'd5;
    localparam logic [2:0] STAT_INFO_LONG = 3'd6;
    localparam logic [2:0] STAT_BAD_FCS   = 3'd7;

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_ADDR,
        PH_CTRL,
        PH_PID,
        PH_INFO
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] address_slot;
        logic [2:0] char_index;
        logic [7:0] value;
        logic       address_is_last;
        logic [2:0] status;
        logic [3:0] repeater_count;
        logic       last;
    } res_t;

    // reflected crc, one byte, lsb first
    function automatic logic [15:0] crc16_x25_byte(input logic [15:0] crc,
                                                   input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/ax25_ui_frame_decoder.sv
// ----------------------------------------------------------------------------
// ax25_ui_frame_decoder
// Streaming decoder for unstuffed AX.25 UI frames with FCS check.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock, flags included, with tlast on the closing
// flag, and sustains one byte per cycle for as long as the sink keeps up. A
// result is registered on its way out: the byte that causes it sits in the
// input register while the frame state update (address, control, pid, info
// holdback and a bytewise CRC-16/X.25 step) runs, and the result register
// loads when that byte is taken. Info bytes come out two bytes late so the
// FCS is never passed on as info, and every frame ends with one verdict
// result carrying the status and repeater count.
// max_info_length may only be written while no frame byte is in flight.
module ax25_ui_frame_decoder
    import axd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,       // max_info_length
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // rx_byte
    input  logic             s_axis_tlast,   // end_of_frame
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // address_slot[3:0], char_index[6:4], value[14:7], address_is_last[15],
    // status[18:16], repeater_count[22:19], zero[23]
    output logic [23:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast    // last
);

    logic     item_valid;
    in_item_t item;
    logic     item_take;
    logic     out_ready;
    logic     res_valid;
    res_t     res;

    axd_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    axd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_ready  (out_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    axd_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .out_ready     (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> rtl/core/axd_in_reg.sv
// ----------------------------------------------------------------------------
// axd_in_reg
// Input register: captures one frame byte per transaction.
// ----------------------------------------------------------------------------
module axd_in_reg
    import axd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    output logic       item_valid,
    output in_item_t   item,
    input  logic       item_take
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_axis_tready = !valid_reg || item_take;

    always_comb
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.rx_byte      <= s_axis_tdata;
            item_reg.end_of_frame <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/core/axd_core.sv
// ----------------------------------------------------------------------------
// axd_core
// Frame state and per-byte decode: address groups, control/pid checks,
// two-byte info holdback, crc and verdict.
// ----------------------------------------------------------------------------
module axd_core
    import axd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             item_valid,
    input  in_item_t         item,
    output logic             item_take,
    input  logic             out_ready,
    output logic             res_valid,
    output res_t             res
);

    logic [CFG_W-1:0]      max_info_reg;
    phase_t                phase_reg,      phase_next;
    logic [2:0]            big_reg,        big_next;
    logic [3:0]            slot_reg,       slot_next;
    logic                  last_bit_reg,   last_bit_next;
    logic [15:0]           crc_reg,        crc_next;
    logic [7:0]            hold0_reg,      hold0_next;
    logic [7:0]            hold1_reg,      hold1_next;
    logic [1:0]            hold_cnt_reg,   hold_cnt_next;
    logic [INFO_CNT_W-1:0] info_cnt_reg,   info_cnt_next;
    logic [2:0]            err_reg,        err_next;

    logic [7:0]       crc_data;
    logic [15:0]      crc_out;
    logic [15:0]      fcs;
    logic [LIM_W-1:0] limit;
    logic [3:0]       reps;
    logic [6:0]       chr;
    logic             ssid_last;
    logic [1:0]       hold_after;

    assign item_take = item_valid && out_ready;

    // info bytes feed the crc as they leave the holdback, header bytes as they arrive
    assign crc_data = (phase_reg == PH_INFO) ? hold0_reg : item.rx_byte;
    assign crc_out  = crc16_x25_byte(crc_reg, crc_data);
    assign fcs      = ~crc_reg;

    assign limit = (LIM_W'(max_info_reg) > LIM_W'(MAX_INFO_BYTES))
                 ? LIM_W'(MAX_INFO_BYTES) : LIM_W'(max_info_reg);

    always_comb
    begin
        if (phase_reg == PH_OPEN)
        begin
            reps = 4'd0;
        end
        else if (phase_reg == PH_ADDR)
        begin
            reps = (slot_reg >= 4'd2) ? slot_reg - 4'd2 : 4'd0;
        end
        else
        begin
            reps = (slot_reg >= 4'd1) ? slot_reg - 4'd1 : 4'd0;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        big_next      = big_reg;
        slot_next     = slot_reg;
        last_bit_next = last_bit_reg;
        crc_next      = crc_reg;
        hold0_next    = hold0_reg;
        hold1_next    = hold1_reg;
        hold_cnt_next = hold_cnt_reg;
        info_cnt_next = info_cnt_reg;
        err_next      = err_reg;
        res_valid     = 1'b0;
        res           = '0;
        chr           = item.rx_byte[7:1];
        ssid_last     = (slot_reg == 4'd0) ? 1'b0 : last_bit_reg;
        hold_after    = hold_cnt_reg;

        if (item_take)
        begin
            if (item.end_of_frame)
            begin
                res_valid          = 1'b1;
                res.kind           = KIND_VERDICT;
                res.repeater_count = reps;
                res.last           = 1'b1;
                if (err_reg != STAT_OK)
                begin
                    res.status = err_reg;
                end
                else if (phase_reg == PH_OPEN)
                begin
                    res.status = (item.rx_byte != FLAG_BYTE) ? STAT_BAD_OPEN : STAT_TRUNC;
                end
                else if (item.rx_byte != FLAG_BYTE)
                begin
                    res.status = STAT_BAD_CLOSE;
                end
                else if (phase_reg != PH_INFO || hold_cnt_reg < 2'd2)
                begin
                    res.status = STAT_TRUNC;
                end
                else if (hold0_reg != fcs[7:0] || hold1_reg != fcs[15:8])
                begin
                    res.status = STAT_BAD_FCS;
                end
                else
                begin
                    res.status = STAT_OK;
                end
                phase_next    = PH_OPEN;
                big_next      = 3'd0;
                slot_next     = 4'd0;
                last_bit_next = 1'b0;
                crc_next      = CRC_INIT;
                hold_cnt_next = 2'd0;
                info_cnt_next = '0;
                err_next      = STAT_OK;
            end
            else if (err_reg == STAT_OK)
            begin
                unique case (phase_reg)
                    PH_OPEN:
                    begin
                        if (item.rx_byte != FLAG_BYTE)
                        begin
                            err_next = STAT_BAD_OPEN;
                        end
                        else
                        begin
                            phase_next = PH_ADDR;
                            big_next   = 3'd0;
                            slot_next  = 4'd0;
                        end
                    end
                    PH_ADDR:
                    begin
                        crc_next  = crc_out;
                        res_valid = 1'b1;
                        if (big_reg < 3'd6)
                        begin
                            if (big_reg == 3'd0)
                            begin
                                last_bit_next = item.rx_byte[0];
                            end
                            if (chr == SPACE_CHAR)
                            begin
                                chr = 7'd0;
                            end
                            big_next         = big_reg + 3'd1;
                            res.kind         = KIND_CHAR;
                            res.address_slot = slot_reg;
                            res.char_index   = big_reg;
                            res.value        = {1'b0, chr};
                        end
                        else
                        begin
                            big_next = 3'd0;
                            if (slot_reg == 4'd0)
                            begin
                                slot_next = 4'd1;
                            end
                            else if (ssid_last || slot_reg >= 4'(MAX_REPEATERS + 1))
                            begin
                                phase_next = PH_CTRL;
                            end
                            else
                            begin
                                slot_next = slot_reg + 4'd1;
                            end
                            res.kind            = KIND_SSID;
                            res.address_slot    = slot_reg;
                            res.value           = {4'd0, item.rx_byte[4:1]};
                            res.address_is_last = ssid_last;
                        end
                    end
                    PH_CTRL:
                    begin
                        crc_next = crc_out;
                        if (item.rx_byte != CTRL_UI)
                        begin
                            err_next = STAT_BAD_CTRL;
                        end
                        else
                        begin
                            phase_next = PH_PID;
                        end
                    end
                    PH_PID:
                    begin
                        crc_next = crc_out;
                        if (item.rx_byte != PID_NONE)
                        begin
                            err_next = STAT_BAD_PID;
                        end
                        else
                        begin
                            phase_next    = PH_INFO;
                            hold_cnt_next = 2'd0;
                            info_cnt_next = '0;
                        end
                    end
                    PH_INFO:
                    begin
                        // oldest held byte leaves once two are waiting
                        if (hold_cnt_reg >= 2'd2)
                        begin
                            hold0_next = hold1_reg;
                            hold_after = 2'd1;
                            crc_next   = crc_out;
                            if (LIM_W'(info_cnt_reg) >= limit)
                            begin
                                err_next = STAT_INFO_LONG;
                            end
                            else
                            begin
                                info_cnt_next = info_cnt_reg + INFO_CNT_W'(1);
                                res_valid     = 1'b1;
                                res.kind      = KIND_INFO;
                                res.value     = hold0_reg;
                            end
                        end
                        if (hold_after == 2'd0)
                        begin
                            hold0_next = item.rx_byte;
                        end
                        else
                        begin
                            hold1_next = item.rx_byte;
                        end
                        hold_cnt_next = hold_after + 2'd1;
                    end
                    default:
                    begin
                        phase_next = PH_OPEN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_info_reg <= CFG_RESET;
            phase_reg    <= PH_OPEN;
            big_reg      <= 3'd0;
            slot_reg     <= 4'd0;
            last_bit_reg <= 1'b0;
            crc_reg      <= CRC_INIT;
            hold_cnt_reg <= 2'd0;
            info_cnt_reg <= '0;
            err_reg      <= STAT_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                max_info_reg <= cfg_data;
            end
            phase_reg    <= phase_next;
            big_reg      <= big_next;
            slot_reg     <= slot_next;
            last_bit_reg <= last_bit_next;
            crc_reg      <= crc_next;
            hold_cnt_reg <= hold_cnt_next;
            info_cnt_reg <= info_cnt_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold0_reg <= hold0_next;
        hold1_reg <= hold1_next;
    end

    // a closing byte always returns the frame state to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && item.end_of_frame) |=>
            (phase_reg == PH_OPEN && err_reg == STAT_OK && hold_cnt_reg == 2'd0))
        else $error("frame state not cleared after verdict");

    // once an error is recorded only the verdict may follow
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && err_reg != STAT_OK) |-> (res.kind == KIND_VERDICT))
        else $error("result emitted after recorded error");

    assert property (@(posedge clk) disable iff (!rst_n)
        (hold_cnt_reg != 2'd3) && (slot_reg <= 4'(MAX_REPEATERS + 1)))
        else $error("holdback count or slot out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (LIM_W'(info_cnt_reg) <= LIM_W'(MAX_INFO_BYTES)))
        else $error("info count beyond capacity");

    // every result is taken by the output stage in the cycle it is made
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (item_take && out_ready))
        else $error("result produced without a taken item");

endmodule

>>> rtl/core/axd_out_reg.sv
// ----------------------------------------------------------------------------
// axd_out_reg
// Result register: holds one decoded result until the sink takes it.
// ----------------------------------------------------------------------------
module axd_out_reg
    import axd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  res_t        res,
    output logic        out_ready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign out_ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = out_ready ? res_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg.repeater_count, res_reg.status,
                            res_reg.address_is_last, res_reg.value,
                            res_reg.char_index, res_reg.address_slot};
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;

endmodule

>>> verif/tb_ax25_ui_frame_decoder.sv
// ----------------------------------------------------------------------------
// tb_ax25_ui_frame_decoder
// Self-checking bench for the streaming AX.25 UI frame decoder. Frames are
// built at random around a well-formed UI layout (repeaters, control, pid,
// info, FCS), with a share of damaged frames and line noise, and driven one
// byte per transaction. A bytewise decode model predicts every result, and
// each accepted result is compared field by field in arrival order. Pacing,
// sink back-pressure and the info-length limit change from phase to phase.
// ----------------------------------------------------------------------------
module tb_ax25_ui_frame_decoder
    import axd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PACE_FULL       = 0;
    localparam int PACE_SRC_IDLE   = 1;
    localparam int PACE_SINK_STALL = 2;
    localparam int PACE_BOTH       = 3;
    localparam int PHASE_ITEMS     = 500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 50000;
    localparam int TIMEOUT_NS      = 5_000_000;

    class ax25_decode_scoreboard;
        res_t             expected_results[$];
        logic [CFG_W-1:0] info_max;
        phase_t           frame_phase;
        logic [2:0]       group_byte;
        logic [3:0]       slot;
        logic             group_last;
        logic [15:0]      crc;
        logic [7:0]       held[2];
        logic [1:0]       held_count;
        int               info_count;
        logic [2:0]       first_error;
        int unsigned      mismatches;
        int unsigned      results_checked;
        int unsigned      kind_count[4];
        int unsigned      verdict_count[8];

        function new();
            info_max = CFG_RESET;
            clear_frame();
        endfunction

        static function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] data);
            logic [15:0] r;
            r = c ^ {8'h00, data};
            repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? CRC_POLY : 16'h0000);
            return r;
        endfunction

        function void clear_frame();
            frame_phase = PH_OPEN;
            group_byte  = '0;
            slot        = '0;
            group_last  = 1'b0;
            crc         = CRC_INIT;
            held[0]     = '0;
            held[1]     = '0;
            held_count  = '0;
            info_count  = 0;
            first_error = STAT_OK;
        endfunction

        function void set_info_limit(input logic [CFG_W-1:0] v);
            info_max = v;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic [3:0] repeaters_done();
            if (frame_phase == PH_OPEN)
                return 4'd0;
            if (frame_phase == PH_ADDR)
                return (slot >= 2) ? slot - 4'd2 : 4'd0;
            return (slot >= 1) ? slot - 4'd1 : 4'd0;
        endfunction

        function void push_result(input res_t r);
            expected_results.push_back(r);
            kind_count[r.kind]++;
        endfunction

        // one frame byte in, zero or one decoded result out
        function void decode_byte(input logic [7:0] b, input logic eof);
            res_t        r;
            logic        last_addr;
            logic [7:0]  released;
            logic [15:0] fcs;
            int          lim;
            r   = '0;
            lim = (info_max < MAX_INFO_BYTES) ? int'(info_max) : MAX_INFO_BYTES;
            if (eof)
            begin
                if (first_error != STAT_OK)
                    r.status = first_error;
                else if (frame_phase == PH_OPEN)
                    r.status = (b != FLAG_BYTE) ? STAT_BAD_OPEN : STAT_TRUNC;
                else if (b != FLAG_BYTE)
                    r.status = STAT_BAD_CLOSE;
                else if (frame_phase != PH_INFO || held_count < 2)
                    r.status = STAT_TRUNC;
                else
                begin
                    fcs = ~crc;
                    r.status = (held[0] == fcs[7:0] && held[1] == fcs[15:8]) ?
                               STAT_OK : STAT_BAD_FCS;
                end
                r.kind           = KIND_VERDICT;
                r.repeater_count = repeaters_done();
                r.last           = 1'b1;
                push_result(r);
                verdict_count[r.status]++;
                clear_frame();
                return;
            end
            if (first_error != STAT_OK)
                return;
            case (frame_phase)
                PH_OPEN:
                begin
                    if (b != FLAG_BYTE)
                        first_error = STAT_BAD_OPEN;
                    else
                    begin
                        frame_phase = PH_ADDR;
                        group_byte  = '0;
                        slot        = '0;
                    end
                end
                PH_ADDR:
                begin
                    crc = crc_step(crc, b);
                    if (group_byte < 6)
                    begin
                        if (group_byte == 0)
                            group_last = b[0];
                        r.kind         = KIND_CHAR;
                        r.address_slot = slot;
                        r.char_index   = group_byte;
                        r.value        = (b[7:1] == SPACE_CHAR) ? 8'h00 : {1'b0, b[7:1]};
                        group_byte++;
                        push_result(r);
                    end
                    else
                    begin
                        // destination never closes the address field
                        last_addr      = (slot == 0) ? 1'b0 : group_last;
                        r.kind         = KIND_SSID;
                        r.address_slot = slot;
                        r.value        = {4'h0, b[4:1]};
                        r.address_is_last = last_addr;
                        group_byte     = '0;
                        if (slot == 0)
                            slot = 4'd1;
                        else if (last_addr || int'(slot) - 1 >= MAX_REPEATERS)
                            frame_phase = PH_CTRL;
                        else
                            slot = slot + 4'd1;
                        push_result(r);
                    end
                end
                PH_CTRL:
                begin
                    crc = crc_step(crc, b);
                    if (b != CTRL_UI)
                        first_error = STAT_BAD_CTRL;
                    else
                        frame_phase = PH_PID;
                end
                PH_PID:
                begin
                    crc = crc_step(crc, b);
                    if (b != PID_NONE)
                        first_error = STAT_BAD_PID;
                    else
                    begin
                        frame_phase = PH_INFO;
                        held_count  = '0;
                        info_count  = 0;
                    end
                end
                default:
                begin
                    // two-byte holdback keeps the fcs out of the info stream
                    if (held_count >= 2)
                    begin
                        released   = held[0];
                        held[0]    = held[1];
                        held_count = 2'd1;
                        crc        = crc_step(crc, released);
                        if (info_count >= lim)
                            first_error = STAT_INFO_LONG;
                        else
                        begin
                            info_count++;
                            r.kind  = KIND_INFO;
                            r.value = released;
                            push_result(r);
                        end
                    end
                    held[held_count[0]] = b;
                    held_count++;
                end
            endcase
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(input res_t got, input logic pad);
            res_t  want;
            string diff;
            results_checked++;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result %h arrived with nothing pending", got));
                return;
            end
            want = expected_results.pop_front();
            diff = "";
            if (got.kind !== want.kind)                       diff = {diff, " kind"};
            if (got.address_slot !== want.address_slot)       diff = {diff, " address_slot"};
            if (got.char_index !== want.char_index)           diff = {diff, " char_index"};
            if (got.value !== want.value)                     diff = {diff, " value"};
            if (got.address_is_last !== want.address_is_last) diff = {diff, " address_is_last"};
            if (got.status !== want.status)                   diff = {diff, " status"};
            if (got.repeater_count !== want.repeater_count)   diff = {diff, " repeater_count"};
            if (got.last !== want.last)                       diff = {diff, " last"};
            if (pad !== 1'b0)                                 diff = {diff, " pad"};
            if (diff != "")
                report_mismatch($sformatf("result %0d differs in%s: got %h, expected %h",
                                          results_checked, diff, got, want));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;
    logic             s_axis_tlast;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [23:0]      m_axis_tdata;
    logic [1:0]       m_axis_tuser;
    logic             m_axis_tlast;

    ax25_decode_scoreboard sb = new();
    logic [7:0] frame_bytes[$];
    int         items_sent;
    int         current_limit;
    int         pace;
    bit         hold_off_req;

    ax25_ui_frame_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit sender_gap();
        if (pace == PACE_SRC_IDLE)
            return $urandom_range(0, 99) < 87;
        if (pace == PACE_BOTH)
            return $urandom_range(0, 99) < 7;
        return 1'b0;
    endfunction

    function automatic bit sink_stall();
        if (pace == PACE_SINK_STALL)
            return $urandom_range(0, 99) < 87;
        if (pace == PACE_BOTH)
            return $urandom_range(0, 99) < 7;
        return 1'b0;
    endfunction

    function automatic logic [6:0] pick_callsign_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return 7'(7'h41 + $urandom_range(0, 25));
        if (sel < 65)
            return 7'(7'h30 + $urandom_range(0, 9));
        if (sel < 80)
            return SPACE_CHAR;
        return 7'($urandom_range(0, 127));
    endfunction

    // mostly well-formed ui frames with random content, some damaged, some noise
    function automatic void build_frame(input int limit);
        int          sel;
        int          fault;
        int          nrep;
        int          payload_len;
        int          cut;
        int          near_pct;
        int          g;
        int          k;
        logic [7:0]  b;
        logic [7:0]  close_byte;
        logic [15:0] fcs;
        frame_bytes.delete();
        sel = $urandom_range(0, 99);
        if (sel < 6)
        begin
            if ($urandom_range(0, 1))
                frame_bytes.push_back(FLAG_BYTE);
            repeat ($urandom_range(0, 10)) frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(($urandom_range(0, 3) != 0) ? FLAG_BYTE : 8'($urandom));
            return;
        end
        nrep = (sel < 20) ? MAX_REPEATERS : $urandom_range(0, MAX_REPEATERS);
        frame_bytes.push_back(FLAG_BYTE);
        for (g = 0; g < nrep + 2; g++)
        begin
            for (k = 0; k < 6; k++)
            begin
                b = {pick_callsign_char(), 1'b0};
                if (k != 0 || g == 0 || (g == nrep + 1 && nrep == MAX_REPEATERS))
                    b[0] = 1'($urandom_range(0, 1));
                else
                    b[0] = (g == nrep + 1);
                frame_bytes.push_back(b);
            end
            frame_bytes.push_back(8'($urandom));
        end
        fault = $urandom_range(0, 99);
        b = CTRL_UI;
        if (fault >= 70 && fault < 74)
            b = CTRL_UI ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(b);
        b = PID_NONE;
        if (fault >= 74 && fault < 78)
            b = PID_NONE ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(b);
        near_pct = (limit <= 40) ? 15 : 5;
        sel = $urandom_range(0, 99);
        if (sel < near_pct)
            payload_len = limit - 1 + $urandom_range(0, 2);
        else if (sel < near_pct + 2)
            payload_len = $urandom_range(0, MAX_INFO_BYTES + 3);
        else
            payload_len = $urandom_range(0, 24);
        repeat (payload_len) frame_bytes.push_back(8'($urandom));
        fcs = CRC_INIT;
        for (k = 1; k < frame_bytes.size(); k++)
            fcs = ax25_decode_scoreboard::crc_step(fcs, frame_bytes[k]);
        fcs = ~fcs;
        if (fault >= 78 && fault < 83)
            fcs = fcs ^ 16'(1 << $urandom_range(0, 15));
        frame_bytes.push_back(fcs[7:0]);
        frame_bytes.push_back(fcs[15:8]);
        close_byte = FLAG_BYTE;
        if (fault >= 83 && fault < 87)
            close_byte = FLAG_BYTE ^ 8'($urandom_range(1, 255));
        if (fault >= 87 && fault < 92)
        begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
        frame_bytes.push_back(close_byte);
        if (fault >= 92 && fault < 97)
        begin
            k = $urandom_range(1, frame_bytes.size() - 1);
            frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
        end
    endfunction

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (sender_gap())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.decode_byte(b, eof);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic drain();
        int w;
        s_axis_tvalid <= 1'b0;
        for (w = 0; w < DRAIN_LIMIT && sb.pending() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_info_limit(input int v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= CFG_W'(v);
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_info_limit(CFG_W'(v));
        current_limit = v;
    endtask

    // sink side: random stalls per pacing mode, plus one long hold-off on request
    initial
    begin
        int k;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                for (k = 0; k < HOLD_OFF_CYCLES; k++)
                begin
                    m_axis_tready <= 1'b0;
                    @(negedge clk);
                end
            end
            m_axis_tready <= !sink_stall();
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind            = m_axis_tuser;
            got.address_slot    = m_axis_tdata[3:0];
            got.char_index      = m_axis_tdata[6:4];
            got.value           = m_axis_tdata[14:7];
            got.address_is_last = m_axis_tdata[15];
            got.status          = m_axis_tdata[18:16];
            got.repeater_count  = m_axis_tdata[22:19];
            got.last            = m_axis_tlast;
            sb.check_result(got, m_axis_tdata[23]);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int         p;
        int         i;
        int         phase_pace[4];
        int         phase_limit[4];
        logic [8:0] directed_items[14];
        int         phase_end;
        // {end_of_frame, byte}: opening-byte end markers, error on the opening
        // byte, cut-short address field with space and extreme bytes, bad close, empty frame
        directed_items = '{9'h17E, 9'h100,
                           9'h0FF, 9'h17E,
                           9'h07E, 9'h000, 9'h0FF, 9'h040, 9'h17E,
                           9'h07E, 9'h082, 9'h1FF,
                           9'h07E, 9'h17E};
        phase_pace  = '{PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH};
        phase_limit = '{256, 1, 255, $urandom_range(2, 40)};
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        items_sent    = 0;
        pace          = PACE_FULL;
        hold_off_req  = 1'b0;
        current_limit = int'(CFG_RESET);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (p = 0; p < 4; p++)
        begin
            pace = phase_pace[p];
            write_info_limit(phase_limit[p]);
            if (p == 0)
            begin
                for (i = 0; i < 14; i++)
                    send_byte(directed_items[i][7:0], directed_items[i][8]);
                // long sink hold-off while a long frame keeps coming
                do
                    build_frame(current_limit);
                while (frame_bytes.size() < 40);
                hold_off_req = 1'b1;
                send_frame();
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                build_frame(current_limit);
                send_frame();
            end
            drain();
        end
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
        $display("run: %0d bytes in, %0d results (%0d chars, %0d ssids, %0d info), 4 pacings",
                 items_sent, sb.results_checked, sb.kind_count[KIND_CHAR],
                 sb.kind_count[KIND_SSID], sb.kind_count[KIND_INFO]);
        $display("frames: ok %0d, open %0d, close %0d, trunc %0d, ctrl %0d, pid %0d, %s",
                 sb.verdict_count[STAT_OK], sb.verdict_count[STAT_BAD_OPEN],
                 sb.verdict_count[STAT_BAD_CLOSE], sb.verdict_count[STAT_TRUNC],
                 sb.verdict_count[STAT_BAD_CTRL], sb.verdict_count[STAT_BAD_PID],
                 $sformatf("long %0d, fcs %0d", sb.verdict_count[STAT_INFO_LONG],
                           sb.verdict_count[STAT_BAD_FCS]));
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
